>>> rtl/owtsd_pkg.sv
package owtsd_pkg;

    // Scratchpad byte positions that carry data or mark the end of a transfer.
    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_TEMP_LSB     = 4'd0;
    localparam logic [POS_W-1:0] POS_TEMP_MSB     = 4'd1;
    localparam logic [POS_W-1:0] POS_CONFIG       = 4'd4;
    localparam logic [POS_W-1:0] POS_COUNT_REMAIN = 4'd6;
    localparam logic [POS_W-1:0] POS_LAST         = 4'd8;
    localparam logic [POS_W-1:0] POS_IDLE         = 4'd9;

    // Family code that selects the count-remain extension.
    localparam logic [7:0] EXT_FAMILY = 8'h10;

    // CRC-8 polynomial in shift-right form.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Offset added in the extended-resolution formula.
    localparam logic [15:0] EXT_OFFSET = 16'd12;

    // Resolution codes from config bits 6:5.
    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_ERR   = 2'd1,
        STATUS_BUS_FAULT = 2'd2
    } status_t;

    // Captured scratchpad fields that feed the temperature conversion.
    typedef struct packed {
        logic [7:0] temp_lsb;
        logic [7:0] temp_msb;
        logic [7:0] cfg_byte;
        logic [7:0] count_remain;
        logic       extended;
    } sensor_fields_t;

endpackage

>>> rtl/onewire_temp_scratchpad_decoder_core.sv
// Scratchpad temperature decoder for a 1-wire temperature sensor.
// Input channel: one scratchpad word per transfer (data_byte) with first_byte
// marking byte 0, family_code sampled with that word, and bus_fault.
// Output channel: one word per complete scratchpad, given with byte 8:
// temperature_tenths (signed, 0.1 degree) and status (0 ok, 1 CRC error,
// 2 bus fault); the temperature is zero unless status is ok.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// out_valid rises when the result register takes the result of byte 8;
// the input register holds byte 8 until the result register is free.
// Throughput: one input word per cycle while in_stall is low; the CRC byte
// update and constant-scaled conversion both fit between the two registers.
// Words after byte 8 without a new first_byte are dropped without a result.
// Reset clears the byte count, CRC, captured bytes and both valid flags.
// When out_stall holds a result, words that make no result still pass;
// byte 8 of the next scratchpad waits, and in_stall rises once the input
// register is occupied by it.
module onewire_temp_scratchpad_decoder_core
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               first_byte,
    input  logic [7:0]         family_code,
    input  logic               bus_fault,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature_tenths,
    output logic [1:0]         status
);

    localparam int unsigned PW = owtsd_pkg::POS_W;

    // Input register.
    logic       in_vld_reg;
    logic [7:0] data_reg;
    logic       first_reg;
    logic [7:0] family_reg;
    logic       fault_in_reg;

    // Scratchpad state.
    logic [PW-1:0] pos_reg,      pos_next;
    logic [7:0]    crc_reg,      crc_next;
    logic [7:0]    temp_lsb_reg, temp_lsb_next;
    logic [7:0]    temp_msb_reg, temp_msb_next;
    logic [7:0]    cfg_reg,      cfg_next;
    logic [7:0]    cremain_reg,  cremain_next;
    logic [7:0]    family_s_reg, family_s_next;
    logic          fault_reg,    fault_next;

    // Result register.
    logic               out_vld_reg;
    logic signed [15:0] temp_out_reg, temp_out_next;
    logic [1:0]         status_reg,   status_next;

    logic          accept;
    logic          fire;
    logic          produce;
    logic [PW-1:0] pos_eff;
    logic [7:0]    crc_eff;
    logic [7:0]    family_eff;
    logic          fault_eff;
    logic [7:0]    crc_upd;
    logic signed [15:0]        tenths;
    owtsd_pkg::sensor_fields_t fields;

    owtsd_crc8 u_crc
    (
        .crc_in  (crc_eff),
        .data_in (data_reg),
        .crc_out (crc_upd)
    );

    assign fields.temp_lsb     = temp_lsb_reg;
    assign fields.temp_msb     = temp_msb_reg;
    assign fields.cfg_byte     = cfg_reg;
    assign fields.count_remain = cremain_reg;
    assign fields.extended     = (family_s_reg == owtsd_pkg::EXT_FAMILY);

    owtsd_convert u_convert
    (
        .fields (fields),
        .tenths (tenths)
    );

    // A start mark restarts the count, CRC and fault flag and samples family.
    assign pos_eff    = first_reg ? owtsd_pkg::POS_TEMP_LSB : pos_reg;
    assign crc_eff    = first_reg ? 8'd0 : crc_reg;
    assign family_eff = first_reg ? family_reg : family_s_reg;
    assign fault_eff  = first_reg ? 1'b0 : fault_reg;

    // Only the last byte makes a result and then needs the output register.
    assign produce  = (pos_eff == owtsd_pkg::POS_LAST);
    assign fire     = in_vld_reg && (!produce || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // Next state of the scratchpad and the result for the held word.
    always_comb
    begin
        pos_next      = pos_eff;
        crc_next      = crc_eff;
        family_s_next = family_eff;
        fault_next    = fault_eff;
        temp_lsb_next = temp_lsb_reg;
        temp_msb_next = temp_msb_reg;
        cfg_next      = cfg_reg;
        cremain_next  = cremain_reg;
        temp_out_next = 16'sd0;
        status_next   = owtsd_pkg::STATUS_OK;

        if (pos_eff > owtsd_pkg::POS_LAST)
        begin
            pos_next = owtsd_pkg::POS_IDLE;
        end
        else if (produce)
        begin
            fault_next = fault_eff | fault_in_reg;
            pos_next   = owtsd_pkg::POS_IDLE;
            if (fault_next)
            begin
                status_next = owtsd_pkg::STATUS_BUS_FAULT;
            end
            else if (crc_eff != data_reg)
            begin
                status_next = owtsd_pkg::STATUS_CRC_ERR;
            end
            else
            begin
                temp_out_next = tenths;
            end
        end
        else
        begin
            fault_next = fault_eff | fault_in_reg;
            crc_next   = crc_upd;
            pos_next   = pos_eff + 1'b1;
            case (pos_eff)
                owtsd_pkg::POS_TEMP_LSB:     temp_lsb_next = data_reg;
                owtsd_pkg::POS_TEMP_MSB:     temp_msb_next = data_reg;
                owtsd_pkg::POS_CONFIG:       cfg_next      = data_reg;
                owtsd_pkg::POS_COUNT_REMAIN: cremain_next  = data_reg;
                default:                     ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg     <= data_byte;
            first_reg    <= first_byte;
            family_reg   <= family_code;
            fault_in_reg <= bus_fault;
        end
    end

    // Scratchpad state, updated as each held word is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            temp_lsb_reg <= '0;
            temp_msb_reg <= '0;
            cfg_reg      <= '0;
            cremain_reg  <= '0;
            family_s_reg <= '0;
            fault_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            temp_lsb_reg <= temp_lsb_next;
            temp_msb_reg <= temp_msb_next;
            cfg_reg      <= cfg_next;
            cremain_reg  <= cremain_next;
            family_s_reg <= family_s_next;
            fault_reg    <= fault_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && produce)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            temp_out_reg <= temp_out_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid          = out_vld_reg;
    assign temperature_tenths = temp_out_reg;
    assign status             = status_reg;

endmodule

>>> rtl/owtsd_crc8.sv
module owtsd_crc8
(
    input  logic [7:0] crc_in,
    input  logic [7:0] data_in,
    output logic [7:0] crc_out
);

    // One byte of the reflected CRC-8, eight bit steps.
    always_comb
    begin
        logic [7:0] c;
        c = crc_in ^ data_in;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ owtsd_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

>>> rtl/owtsd_convert.sv
module owtsd_convert
(
    input  owtsd_pkg::sensor_fields_t fields,
    output logic signed [15:0]        tenths
);

    logic [15:0]        raw;
    logic [15:0]        raw_adj;
    logic signed [18:0] sval;
    logic signed [18:0] scaled;
    logic signed [18:0] rounded;
    logic signed [18:0] quotient;

    assign raw = {fields.temp_msb, fields.temp_lsb};

    // Extended mode rebuilds the raw value from count-remain; otherwise the
    // undefined low bits are cleared according to the resolution.
    always_comb
    begin
        raw_adj = raw;
        if (fields.extended)
        begin
            raw_adj = ((raw & 16'hFFFE) << 3) + owtsd_pkg::EXT_OFFSET
                      - {8'd0, fields.count_remain};
        end
        else
        begin
            case (fields.cfg_byte[6:5])
                owtsd_pkg::RES_9BIT:  raw_adj = raw & 16'hFFF8;
                owtsd_pkg::RES_10BIT: raw_adj = raw & 16'hFFFC;
                owtsd_pkg::RES_11BIT: raw_adj = raw & 16'hFFFE;
                default:              raw_adj = raw;
            endcase
        end
    end

    // (raw*625+500)/1000 equals (5*raw+4)/8, truncated toward zero.
    assign sval     = $signed({{3{raw_adj[15]}}, raw_adj});
    assign scaled   = (sval <<< 2) + sval + 19'sd4;
    assign rounded  = scaled[18] ? scaled + 19'sd7 : scaled;
    assign quotient = rounded >>> 3;
    assign tenths   = quotient[15:0];

endmodule
